FILE: src/hclp_pkg.sv
// Package with the character codes and hex-digit decode for the color list parser.
package hclp_pkg;

    // Character codes that the parser recognizes
    localparam logic [7:0] CharComma   = 8'h2C;
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharHash    = 8'h23;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharLowerA  = 8'h61;
    localparam logic [7:0] CharLowerF  = 8'h66;
    localparam logic [7:0] CharUpperA  = 8'h41;
    localparam logic [7:0] CharUpperF  = 8'h46;

    // Token bookkeeping limits
    localparam logic [3:0] CountFull   = 4'd9;
    localparam logic [3:0] CountSat    = 4'd10;
    localparam logic [3:0] CountDigLo  = 4'd1;
    localparam logic [3:0] CountDigHi  = 4'd8;

    // Register map
    localparam int         AddrWidth       = 3;
    localparam logic       RegDefaultColor = 1'b0;
    localparam logic [31:0] DefaultColorReset = 32'h0000_0000;

    // Result of decoding one character as a hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one character as a hex digit in either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t d;
        logic [7:0] diff;
        d.valid = 1'b0;
        d.value = 4'd0;
        diff    = 8'd0;
        if (ch >= CharZero && ch <= CharNine) begin
            diff    = ch - CharZero;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (ch >= CharLowerA && ch <= CharLowerF) begin
            diff    = ch - CharLowerA + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (ch >= CharUpperA && ch <= CharUpperF) begin
            diff    = ch - CharUpperA + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

FILE: src/hex_color_list_parser.sv
// A result is registered: it appears at the outputs in the cycle after the item that causes it.
// Throughput: one item per cycle while out_ready is high; token state and result update together.
// A result that waits for out_ready holds in_ready low until it is taken.
// Reset (rst_n low, asynchronous) clears the token state, the result valid flag and
// default_color to zero.
module hex_color_list_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        char_byte,
    input  logic                              end_of_list,
    // Output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [7:0]                        white,
    output logic                              color_present,
    output logic                              well_formed,
    output logic                              list_end,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hclp_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // Token state
    logic        token_started_reg, token_started_next;
    logic        trailing_space_reg, trailing_space_next;
    logic        token_bad_reg, token_bad_next;
    logic [3:0]  body_count_reg, body_count_next;
    logic [31:0] color_accum_reg, color_accum_next;
    logic [31:0] default_color_reg;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_color_reg;
    logic        out_present_reg, out_good_reg, out_end_reg;

    logic                 accept;
    logic                 is_comma, is_space;
    hclp_pkg::hex_digit_t digit;
    logic                 emit, emit_present, emit_good;
    logic [31:0]          emit_color;
    logic                 in_digit_range;

    // Configuration writes and reads
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= hclp_pkg::DefaultColorReset;
        end
        else if (psel && penable && pwrite && paddr[2] == hclp_pkg::RegDefaultColor)
        begin
            default_color_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == hclp_pkg::RegDefaultColor) ? default_color_reg : 32'd0;

    // Handshake: a new item enters when the result register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Character classification
    assign is_comma       = (char_byte == hclp_pkg::CharComma);
    assign is_space       = (char_byte == hclp_pkg::CharSpace);
    assign digit          = hclp_pkg::hex_decode(char_byte);
    assign in_digit_range = (body_count_reg >= hclp_pkg::CountDigLo) &&
                            (body_count_reg <= hclp_pkg::CountDigHi);

    // Color of the current token, as it would be reported now
    assign emit_present = token_started_reg;
    assign emit_good    = token_started_reg && !token_bad_reg &&
                          (body_count_reg == hclp_pkg::CountFull);
    assign emit_color   = !token_started_reg ? 32'd0 :
                          (emit_good ? color_accum_reg : default_color_reg);

    // An end item always gives a result; a comma gives one for a non-blank token
    assign emit = end_of_list || (is_comma && token_started_reg);

    // Next token state for the item at the input
    always_comb
    begin
        token_started_next  = token_started_reg;
        trailing_space_next = trailing_space_reg;
        token_bad_next      = token_bad_reg;
        body_count_next     = body_count_reg;
        color_accum_next    = color_accum_reg;
        if (end_of_list || is_comma)
        begin
            token_started_next  = 1'b0;
            trailing_space_next = 1'b0;
            token_bad_next      = 1'b0;
            body_count_next     = 4'd0;
            color_accum_next    = 32'd0;
        end
        else if (is_space)
        begin
            if (token_started_reg)
            begin
                trailing_space_next = 1'b1;
            end
        end
        else if (!token_started_reg)
        begin
            token_started_next = 1'b1;
            token_bad_next     = (char_byte != hclp_pkg::CharHash);
            body_count_next    = 4'd1;
            color_accum_next   = 32'd0;
        end
        else
        begin
            // A character after an inner space, a non-digit or a tenth character spoils it
            token_bad_next = token_bad_reg || trailing_space_reg ||
                             !in_digit_range || !digit.valid;
            if (in_digit_range && digit.valid)
            begin
                color_accum_next = {color_accum_reg[27:0], digit.value};
            end
            if (body_count_reg < hclp_pkg::CountSat)
            begin
                body_count_next = body_count_reg + 4'd1;
            end
        end
    end

    // Token state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_started_reg  <= 1'b0;
            trailing_space_reg <= 1'b0;
            token_bad_reg      <= 1'b0;
            body_count_reg     <= 4'd0;
            color_accum_reg    <= 32'd0;
        end
        else if (accept)
        begin
            token_started_reg  <= token_started_next;
            trailing_space_reg <= trailing_space_next;
            token_bad_reg      <= token_bad_next;
            body_count_reg     <= body_count_next;
            color_accum_reg    <= color_accum_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_color_reg   <= emit_color;
            out_present_reg <= emit_present;
            out_good_reg    <= emit_good;
            out_end_reg     <= end_of_list;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = out_color_reg[31:24];
    assign green         = out_color_reg[23:16];
    assign blue          = out_color_reg[15:8];
    assign white         = out_color_reg[7:0];
    assign color_present = out_present_reg;
    assign well_formed   = out_good_reg;
    assign list_end      = out_end_reg;

    // An accepted end item always leaves a list-end result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_list |=> out_valid && list_end)
        else $error("end item gave no list-end result");

    // A well-formed result always carries a color
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && well_formed |-> color_present)
        else $error("well-formed result without a color");

    // The character count saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        body_count_reg <= hclp_pkg::CountSat)
        else $error("body count past saturation");

    // A token that has not started holds no count and no space mark
    assert property (@(posedge clk) disable iff (!rst_n)
        !token_started_reg |-> body_count_reg == 4'd0 && !trailing_space_reg && !token_bad_reg)
        else $error("blank token carries stale state");

endmodule
